// ----- rtl/core/pcec_pkg.sv -----
// Shared widths, default parameters and parity-check matrix helpers for the codec.
`default_nettype none
package pcec_pkg;

   // Fixed port widths
   localparam int DATA_W     = 32;
   localparam int CODEWORD_W = 40;
   localparam int SYNDROME_W = 8;

   // Widest row mask the matrix can need (48 data + 16 check bits)
   localparam int MASK_W = 64;

   // Default code shape
   localparam int DATA_BITS_DEF      = 32;
   localparam int CHECK_BITS_DEF     = 8;
   localparam int ROW_WEIGHT_MAX_DEF = 8;

   // Build the coverage mask of check row r: the lowest data bits with index
   // congruent to r, up to the weight limit, then its own parity bit if a slot is left.
   function automatic logic [MASK_W-1:0] row_cover(input int r, input int data_bits,
                                                   input int check_bits, input int weight_max);
      logic [MASK_W-1:0] m;
      int                w;
      int                k;
      m = '0;
      w = 0;
      k = 0;
      for (int c = 0; c < data_bits; c++) begin
         if (k == r && w < weight_max) begin
            m[c] = 1'b1;
            w    = w + 1;
         end
         k = (k == check_bits - 1) ? 0 : k + 1;
      end
      if (w < weight_max) begin
         m[data_bits + r] = 1'b1;
      end
      return m;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/pcec_syn_stage.sv -----
// Syndrome stage: row parity trees, parity insertion on encode, one register stage.
`default_nettype none
module pcec_syn_stage #(
   parameter int DATA_BITS      = pcec_pkg::DATA_BITS_DEF,
   parameter int CHECK_BITS     = pcec_pkg::CHECK_BITS_DEF,
   parameter int ROW_WEIGHT_MAX = pcec_pkg::ROW_WEIGHT_MAX_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             enable,
   input  wire logic                             in_valid,
   input  wire logic                             in_decode,
   input  wire logic [DATA_BITS+CHECK_BITS-1:0]  in_word,
   output logic                                  out_valid,
   output logic                                  out_decode,
   output logic [DATA_BITS+CHECK_BITS-1:0]       out_word,
   output logic [CHECK_BITS-1:0]                 out_syndrome
);
   import pcec_pkg::*;

   localparam int CW = DATA_BITS + CHECK_BITS;

   logic [CW-1:0]         rows [CHECK_BITS];
   logic [CHECK_BITS-1:0] syn;
   logic                  valid_ff, valid_in;
   logic                  decode_ff;
   logic [CW-1:0]         word_ff, word_in;
   logic [CHECK_BITS-1:0] syn_ff, syn_in;

   // Constant matrix rows
   for (genvar r = 0; r < CHECK_BITS; r++) begin : g_row
      localparam logic [MASK_W-1:0] ROW_MASK =
         row_cover(r, DATA_BITS, CHECK_BITS, ROW_WEIGHT_MAX);
      assign rows[r] = ROW_MASK[CW-1:0];
      assign syn[r]  = ^(in_word & rows[r]);
   end

   // Encode: parity bits of the incoming word are zero, so the syndrome is the parity
   always_comb begin
      if (in_decode) begin
         word_in = in_word;
         syn_in  = syn;
      end else begin
         word_in                       = in_word;
         word_in[CW-1:DATA_BITS]       = syn;
         syn_in                        = '0;
      end
   end

   // Hold while the next stage is blocked
   assign valid_in = enable ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         decode_ff <= in_decode;
         word_ff   <= word_in;
         syn_ff    <= syn_in;
      end
   end

   assign out_valid    = valid_ff;
   assign out_decode   = decode_ff;
   assign out_word     = word_ff;
   assign out_syndrome = syn_ff;

endmodule
`default_nettype wire

// ----- rtl/core/pcec_locate_stage.sv -----
// Locate stage: compare the syndrome with every column and pick the first match.
`default_nettype none
module pcec_locate_stage #(
   parameter int DATA_BITS      = pcec_pkg::DATA_BITS_DEF,
   parameter int CHECK_BITS     = pcec_pkg::CHECK_BITS_DEF,
   parameter int ROW_WEIGHT_MAX = pcec_pkg::ROW_WEIGHT_MAX_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             enable,
   input  wire logic                             in_valid,
   input  wire logic [DATA_BITS+CHECK_BITS-1:0]  in_word,
   input  wire logic [CHECK_BITS-1:0]            in_syndrome,
   output logic                                  out_valid,
   output logic [DATA_BITS+CHECK_BITS-1:0]       out_word,
   output logic [CHECK_BITS-1:0]                 out_syndrome,
   output logic [DATA_BITS+CHECK_BITS-1:0]       out_flip,
   output logic                                  out_bad
);
   import pcec_pkg::*;

   localparam int CW = DATA_BITS + CHECK_BITS;

   logic [CHECK_BITS-1:0] sig [CW];
   logic [CW-1:0]         match;
   logic [CW-1:0]         first;
   logic                  valid_ff, valid_in;
   logic [CW-1:0]         word_ff;
   logic [CHECK_BITS-1:0] syn_ff;
   logic [CW-1:0]         flip_ff;
   logic                  bad_ff, bad_in;

   // Column signatures from the constant rows
   for (genvar r = 0; r < CHECK_BITS; r++) begin : g_row
      localparam logic [MASK_W-1:0] ROW_MASK =
         row_cover(r, DATA_BITS, CHECK_BITS, ROW_WEIGHT_MAX);
      for (genvar c = 0; c < CW; c++) begin : g_col
         assign sig[c][r] = ROW_MASK[c];
      end
   end

   // Match every column; a zero syndrome matches nothing
   for (genvar c = 0; c < CW; c++) begin : g_match
      assign match[c] = (sig[c] == in_syndrome) && (in_syndrome != '0);
   end

   // Keep the lowest matching column
   assign first  = match & (~match + CW'(1));
   assign bad_in = (in_syndrome != '0) && (match == '0);

   assign valid_in = enable ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         word_ff <= in_word;
         syn_ff  <= in_syndrome;
         flip_ff <= first;
         bad_ff  <= bad_in;
      end
   end

   assign out_valid    = valid_ff;
   assign out_word     = word_ff;
   assign out_syndrome = syn_ff;
   assign out_flip     = flip_ff;
   assign out_bad      = bad_ff;

endmodule
`default_nettype wire

// ----- rtl/core/parity_check_encode_correct.sv -----
// Top level of the parity-check encoder / single-error corrector pipeline.
//
// Encodes a data word by appending one XOR parity bit per check row, or decodes a
// codeword: computes its syndrome, flips the first column whose matrix column equals
// a nonzero syndrome, and flags the word uncorrectable if no column matches (data_out
// is then zero and the codeword is returned unflipped). One request is taken every
// cycle unless req_stall is high. A request passes through four register stages:
// input register, syndrome trees, column match, and output register with the flip
// applied. Each stage holds its request while the one after it is full and blocked,
// so empty stages still fill behind a stalled result. The matrix is fixed by
// DATA_BITS, CHECK_BITS and ROW_WEIGHT_MAX; only the low eight syndrome bits are
// reported.
`default_nettype none
module parity_check_encode_correct #(
   parameter int DATA_BITS      = pcec_pkg::DATA_BITS_DEF,
   parameter int CHECK_BITS     = pcec_pkg::CHECK_BITS_DEF,
   parameter int ROW_WEIGHT_MAX = pcec_pkg::ROW_WEIGHT_MAX_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_type,
   input  wire logic [pcec_pkg::DATA_W-1:0]       req_data_in,
   input  wire logic [pcec_pkg::CODEWORD_W-1:0]   req_codeword_in,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [pcec_pkg::CODEWORD_W-1:0]        rsp_codeword_out,
   output logic [pcec_pkg::DATA_W-1:0]            rsp_data_out,
   output logic [pcec_pkg::SYNDROME_W-1:0]        rsp_syndrome,
   output logic                                   rsp_status,
   output logic                                   rsp_corrected_count
);
   import pcec_pkg::*;

   localparam int CW = DATA_BITS + CHECK_BITS;

   // Stage enables, from the output back
   logic en_out, en_loc, en_syn, en_in;

   // Input stage
   logic          in_valid_ff, in_valid_in;
   logic          in_decode_ff;
   logic [CW-1:0] in_word_ff, in_word_in;

   // Syndrome stage
   logic                  syn_valid, syn_decode;
   logic [CW-1:0]         syn_word;
   logic [CHECK_BITS-1:0] syn_value;

   // Locate stage
   logic                  loc_valid, loc_bad;
   logic [CW-1:0]         loc_word, loc_flip;
   logic [CHECK_BITS-1:0] loc_syndrome;

   // Output stage
   logic                  out_valid_ff, out_valid_in;
   logic [CW-1:0]         fixed_word;
   logic [CODEWORD_W-1:0] codeword_ff;
   logic [DATA_W-1:0]     data_ff, data_in;
   logic [SYNDROME_W-1:0] syndrome_ff;
   logic                  status_ff;
   logic                  count_ff;

   assign en_out = !out_valid_ff || !rsp_stall;
   assign en_loc = !loc_valid || en_out;
   assign en_syn = !syn_valid || en_loc;
   assign en_in  = !in_valid_ff || en_syn;

   assign req_stall = !en_in;

   // Capture the request; mask to the code size
   assign in_word_in  = req_type ? CW'(req_codeword_in) : CW'(DATA_BITS'(req_data_in));
   assign in_valid_in = en_in ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_in) begin
         in_decode_ff <= req_type;
         in_word_ff   <= in_word_in;
      end
   end

   pcec_syn_stage #(
      .DATA_BITS      (DATA_BITS),
      .CHECK_BITS     (CHECK_BITS),
      .ROW_WEIGHT_MAX (ROW_WEIGHT_MAX)
   ) u_syn (
      .clock        (clock),
      .reset        (reset),
      .enable       (en_syn),
      .in_valid     (in_valid_ff),
      .in_decode    (in_decode_ff),
      .in_word      (in_word_ff),
      .out_valid    (syn_valid),
      .out_decode   (syn_decode),
      .out_word     (syn_word),
      .out_syndrome (syn_value)
   );

   pcec_locate_stage #(
      .DATA_BITS      (DATA_BITS),
      .CHECK_BITS     (CHECK_BITS),
      .ROW_WEIGHT_MAX (ROW_WEIGHT_MAX)
   ) u_locate (
      .clock        (clock),
      .reset        (reset),
      .enable       (en_loc),
      .in_valid     (syn_valid),
      .in_word      (syn_word),
      .in_syndrome  (syn_decode ? syn_value : '0),
      .out_valid    (loc_valid),
      .out_word     (loc_word),
      .out_syndrome (loc_syndrome),
      .out_flip     (loc_flip),
      .out_bad      (loc_bad)
   );

   // Apply the flip; drop the data of an uncorrectable word
   assign fixed_word   = loc_word ^ loc_flip;
   assign data_in      = loc_bad ? '0 : DATA_W'(fixed_word[DATA_BITS-1:0]);
   assign out_valid_in = en_out ? loc_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         codeword_ff <= CODEWORD_W'(fixed_word);
         data_ff     <= data_in;
         syndrome_ff <= SYNDROME_W'(loc_syndrome);
         status_ff   <= loc_bad;
         count_ff    <= |loc_flip;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_codeword_out    = codeword_ff;
   assign rsp_data_out        = data_ff;
   assign rsp_syndrome        = syndrome_ff;
   assign rsp_status          = status_ff;
   assign rsp_corrected_count = count_ff;

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the parity-check encoder and single-error corrector.
`timescale 1ns / 1ps

module testbench;
   import pcec_pkg::*;

   localparam int DATA_BITS      = DATA_BITS_DEF;
   localparam int CHECK_BITS     = CHECK_BITS_DEF;
   localparam int ROW_WEIGHT_MAX = ROW_WEIGHT_MAX_DEF;
   localparam int CW_BITS        = DATA_BITS + CHECK_BITS;

   localparam int RANDOM_ITEMS   = 1300;
   localparam int IDLE_LIMIT     = 2000;
   localparam int TAIL_CYCLES    = 12;
   localparam int REPORT_LIMIT   = 10;

   localparam logic STATUS_OK            = 1'b0;
   localparam logic STATUS_UNCORRECTABLE = 1'b1;

   typedef enum logic {
      OP_ENCODE = 1'b0,
      OP_DECODE = 1'b1
   } codec_op_type;

   typedef struct packed {
      codec_op_type          op;
      logic [DATA_W-1:0]     data;
      logic [CODEWORD_W-1:0] codeword;
      logic                  drain_first;
   } codec_req_type;

   typedef struct packed {
      logic [CODEWORD_W-1:0] codeword;
      logic [DATA_W-1:0]     data;
      logic [SYNDROME_W-1:0] syndrome;
      logic                  status;
      logic                  corrected;
   } codec_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_type = 1'b0;
   logic [DATA_W-1:0]     req_data_in = '0;
   logic [CODEWORD_W-1:0] req_codeword_in = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CODEWORD_W-1:0] rsp_codeword_out;
   logic [DATA_W-1:0]     rsp_data_out;
   logic [SYNDROME_W-1:0] rsp_syndrome;
   logic                  rsp_status;
   logic                  rsp_corrected_count;

   logic [MASK_W-1:0] row_mask [CHECK_BITS];
   codec_req_type     pending_reqs [$];
   codec_rsp_type     expected_rsps [$];
   codec_req_type     cur_req;
   int                error_count = 0;
   int                burst_left = 0;
   int                gap_left = 0;
   int                idle_cycles = 0;
   logic [9:0]        stall_phase = '0;

   parity_check_encode_correct #(
      .DATA_BITS      (DATA_BITS),
      .CHECK_BITS     (CHECK_BITS),
      .ROW_WEIGHT_MAX (ROW_WEIGHT_MAX)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_data_in         (req_data_in),
      .req_codeword_in     (req_codeword_in),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_codeword_out    (rsp_codeword_out),
      .rsp_data_out        (rsp_data_out),
      .rsp_syndrome        (rsp_syndrome),
      .rsp_status          (rsp_status),
      .rsp_corrected_count (rsp_corrected_count)
   );

   // Free-running clock
   initial begin
      forever #5 clock = ~clock;
   end

   function automatic codec_req_type make_req(input codec_op_type op,
                                              input logic [DATA_W-1:0] d,
                                              input logic [CODEWORD_W-1:0] cw);
      codec_req_type rq;
      rq.op          = op;
      rq.data        = d;
      rq.codeword    = cw;
      rq.drain_first = 1'b0;
      return rq;
   endfunction

   // Parity of each check row over a full codeword
   function automatic logic [15:0] parity_syndrome(input logic [MASK_W-1:0] cw);
      logic [15:0] s;
      s = '0;
      for (int r = 0; r < CHECK_BITS; r++) begin
         s[r] = ^(cw & row_mask[r]);
      end
      return s;
   endfunction

   // Expected result of one request: encode, or decode with single-column correction
   function automatic codec_rsp_type codec_predict(input codec_req_type rq);
      codec_rsp_type     rs;
      logic [MASK_W-1:0] d;
      logic [MASK_W-1:0] cw;
      logic [MASK_W-1:0] fixed;
      logic [15:0]       syn;
      logic [15:0]       sig;
      logic              found;
      int                pos;
      rs    = '0;
      syn   = '0;
      found = 1'b0;
      pos   = 0;
      d     = '0;
      if (rq.op == OP_ENCODE) begin
         d[DATA_BITS-1:0] = rq.data[DATA_BITS-1:0];
         cw = d;
         for (int r = 0; r < CHECK_BITS; r++) begin
            cw[DATA_BITS + r] = ^(d & row_mask[r]);
         end
         rs.data   = d[DATA_W-1:0];
         rs.status = STATUS_OK;
      end else begin
         cw = '0;
         cw[CW_BITS-1:0] = rq.codeword[CW_BITS-1:0];
         syn = parity_syndrome(cw);
         rs.status = STATUS_OK;
         if (syn != 0) begin
            // Find the first column whose signature equals the syndrome
            for (int c = 0; c < CW_BITS; c++) begin
               sig = '0;
               for (int r = 0; r < CHECK_BITS; r++) begin
                  sig[r] = row_mask[r][c];
               end
               if (!found && sig == syn) begin
                  found = 1'b1;
                  pos   = c;
               end
            end
            if (found) begin
               fixed = cw ^ (64'h1 << pos);
               if (parity_syndrome(fixed) != 0) begin
                  rs.status = STATUS_UNCORRECTABLE;
               end else begin
                  cw           = fixed;
                  rs.corrected = 1'b1;
               end
            end else begin
               rs.status = STATUS_UNCORRECTABLE;
            end
         end
         // Keep only the data bits of the corrected word
         if (rs.status == STATUS_OK) begin
            d[DATA_BITS-1:0] = cw[DATA_BITS-1:0];
            rs.data = d[DATA_W-1:0];
         end
      end
      rs.codeword = cw[CODEWORD_W-1:0];
      rs.syndrome = syn[SYNDROME_W-1:0];
      return rs;
   endfunction

   function automatic logic [CODEWORD_W-1:0] encode_word(input logic [DATA_W-1:0] d);
      codec_rsp_type rs;
      rs = codec_predict(make_req(OP_ENCODE, d, '0));
      return rs.codeword;
   endfunction

   task automatic note_mismatch(input string what, input logic [63:0] exp_val,
                                input logic [63:0] act_val);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("mismatch on %s: expected %h, actual %h", what, exp_val, act_val);
      end
   endtask

   // Build the matrix, queue the requests, release reset and wait for the drain
   initial begin
      logic [MASK_W-1:0]     m;
      logic [63:0]           wide;
      logic [DATA_W-1:0]     d;
      logic [CODEWORD_W-1:0] cw;
      codec_req_type         rq;
      int                    w;
      int                    kind;
      for (int r = 0; r < CHECK_BITS; r++) begin
         m = '0;
         w = 0;
         for (int c = 0; c < DATA_BITS; c++) begin
            if ((c % CHECK_BITS) == r && w < ROW_WEIGHT_MAX) begin
               m[c] = 1'b1;
               w++;
            end
         end
         if (w < ROW_WEIGHT_MAX) begin
            m[DATA_BITS + r] = 1'b1;
         end
         row_mask[r] = m;
      end

      // Directed: data extremes, clean words, single and double errors
      pending_reqs.push_back(make_req(OP_ENCODE, '0, '1));
      pending_reqs.push_back(make_req(OP_ENCODE, '1, '0));
      pending_reqs.push_back(make_req(OP_ENCODE, 32'hAAAA_AAAA, 40'h55_5555_5555));
      pending_reqs.push_back(make_req(OP_ENCODE, 32'h5555_5555, 40'hAA_AAAA_AAAA));
      pending_reqs.push_back(make_req(OP_ENCODE, 32'h8000_0001, '0));
      pending_reqs.push_back(make_req(OP_DECODE, '1, '0));
      pending_reqs.push_back(make_req(OP_DECODE, '0, '1));
      cw = encode_word('1);
      pending_reqs.push_back(make_req(OP_DECODE, '0, cw));
      pending_reqs.push_back(make_req(OP_DECODE, '0, cw ^ 40'h1));
      pending_reqs.push_back(make_req(OP_DECODE, '0, cw ^ (40'h1 << (DATA_BITS - 1))));
      pending_reqs.push_back(make_req(OP_DECODE, '0, cw ^ (40'h1 << DATA_BITS)));
      pending_reqs.push_back(make_req(OP_DECODE, '0, cw ^ (40'h1 << (CW_BITS - 1))));
      cw = encode_word(32'h1234_5678);
      pending_reqs.push_back(make_req(OP_DECODE, '1, cw));
      // Two errors in different rows cannot be corrected
      pending_reqs.push_back(make_req(OP_DECODE, '0, cw ^ 40'h3));
      // Two errors in one row cancel in the syndrome
      pending_reqs.push_back(make_req(OP_DECODE, '0, cw ^ 40'h101));
      // Error on a data bit whose column shares a signature with an earlier one
      pending_reqs.push_back(make_req(OP_DECODE, '0, cw ^ (40'h1 << 13)));
      pending_reqs.push_back(make_req(OP_DECODE, '0, cw ^ 40'hFF_0000_0000));
      pending_reqs.push_back(make_req(OP_DECODE, '0, 40'h80_0000_0001));
      pending_reqs.push_back(make_req(OP_DECODE, '0, encode_word('0) ^ 40'h1_0000_0080));

      // Random: mostly encodable words with 0..2 errors, some raw noise
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         d    = $urandom();
         wide = {$urandom(), $urandom()};
         kind = $urandom_range(0, 9);
         cw   = encode_word(d);
         if (kind <= 2) begin
            rq = make_req(OP_ENCODE, d, wide[CODEWORD_W-1:0]);
         end else if (kind <= 5) begin
            rq = make_req(OP_DECODE, wide[63:32],
                          cw ^ (40'h1 << $urandom_range(0, CW_BITS - 1)));
         end else if (kind == 6) begin
            rq = make_req(OP_DECODE, wide[63:32], cw);
         end else if (kind == 7) begin
            rq = make_req(OP_DECODE, wide[63:32],
                          cw ^ (40'h1 << $urandom_range(0, CW_BITS - 1))
                             ^ (40'h1 << $urandom_range(0, CW_BITS - 1)));
         end else begin
            rq = make_req(OP_DECODE, d, wide[CODEWORD_W-1:0]);
         end
         if (i == RANDOM_ITEMS / 2 || i == (RANDOM_ITEMS * 3) / 4) begin
            rq.drain_first = 1'b1;
         end
         pending_reqs.push_back(rq);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Driver: present queued requests in bursts, hold while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = $urandom_range(1, 32);
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(codec_predict(cur_req));
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() == 0 ||
                         (pending_reqs[0].drain_first && expected_rsps.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               cur_req = pending_reqs.pop_front();
               req_type        <= cur_req.op;
               req_data_in     <= cur_req.data;
               req_codeword_in <= cur_req.codeword;
               req_valid       <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 32);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // Monitor: stall on a phase pattern, check each accepted result
   always @(posedge clock) begin
      codec_rsp_type exp_rsp;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_phase <= stall_phase + 10'd1;
         case (stall_phase[9:8])
            2'd0: begin
               rsp_stall <= 1'b0;
            end
            2'd1: begin
               rsp_stall <= ($urandom_range(0, 1) == 1);
            end
            2'd2: begin
               rsp_stall <= (stall_phase[1:0] != 2'd0);
            end
            default: begin
               rsp_stall <= ($urandom_range(0, 7) == 0);
            end
         endcase
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               note_mismatch("result with no request pending", '0, 64'(rsp_codeword_out));
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_codeword_out !== exp_rsp.codeword)
                  note_mismatch("codeword_out", 64'(exp_rsp.codeword),
                                64'(rsp_codeword_out));
               if (rsp_data_out !== exp_rsp.data)
                  note_mismatch("data_out", 64'(exp_rsp.data), 64'(rsp_data_out));
               if (rsp_syndrome !== exp_rsp.syndrome)
                  note_mismatch("syndrome", 64'(exp_rsp.syndrome), 64'(rsp_syndrome));
               if (rsp_status !== exp_rsp.status)
                  note_mismatch("status", 64'(exp_rsp.status), 64'(rsp_status));
               if (rsp_corrected_count !== exp_rsp.corrected)
                  note_mismatch("corrected_count", 64'(exp_rsp.corrected),
                                64'(rsp_corrected_count));
            end
         end
      end
   end

   // Watchdog: end the run when no request or result moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

endmodule
